FILE: hw/rtl/bsw_pkg.sv
// Shared types and constants for the binary semaphore wait queue.
// No dependencies.
`timescale 1ns / 1ps

package bsw_pkg;

   localparam int MAX_THREADS = 64;
   localparam int THREAD_W    = 6;
   localparam int IDX_W       = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);
   localparam int STATUS_W    = 3;

   localparam logic FUNC_DOWN = 1'b0;
   localparam logic FUNC_UP   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ACQUIRED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd4;

   typedef struct packed {
      logic                func;
      logic [THREAD_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [THREAD_W-1:0] woken_thread;
      logic [CNT_W-1:0]    waiters;
   } rsp_type;

endpackage

FILE: hw/rtl/bsw_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/binary_semaphore_wait_queue.sv
// Binary semaphore with a FIFO ring of waiting thread numbers.
// A taken request gives its result beat in the cycle after, unless csr_we is also high.
// Throughput: one request per cycle; busy never rises. The wait ring sits in
// bsw_ram, read at the head on an up beat and written at the tail on a down.
// Synchronous reset frees the lock and empties the ring (no clearing pass).
// The result beat cannot be stalled. Uses bsw_pkg and bsw_ram.
`timescale 1ns / 1ps

module binary_semaphore_wait_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bsw_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   import bsw_pkg::*;

   logic                lock_free_ff, lock_free_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    waiters_ff, waiters_in;

   logic                accept;
   logic                push;
   logic                pop;
   logic [THREAD_W-1:0] ring_rdata;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_THREADS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_THREADS);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      lock_free_in = lock_free_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      push         = 1'b0;
      pop          = 1'b0;
      if (csr_we) begin
         lock_free_in = csr_wdata;
         head_in      = '0;
         tail_in      = '0;
         count_in     = '0;
      end else if (accept) begin
         if (req_data.func == FUNC_DOWN) begin
            if (lock_free_ff) begin
               lock_free_in = 1'b0;
               status_in    = ST_ACQUIRED;
            end else if (count_ff == FULL_CNT) begin
               status_in = ST_DROPPED;
            end else begin
               push      = 1'b1;
               tail_in   = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_ONE;
               count_in  = count_ff + CNT_ONE;
               status_in = ST_QUEUED;
            end
         end else begin
            if (count_ff != '0) begin
               pop       = 1'b1;
               head_in   = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_ONE;
               count_in  = count_ff - CNT_ONE;
               status_in = ST_WOKEN;
            end else begin
               lock_free_in = 1'b1;
               status_in    = ST_FREED;
            end
         end
      end
      rsp_valid_in = accept && !csr_we;
      waiters_in   = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_free_ff <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lock_free_ff <= lock_free_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      waiters_ff <= waiters_in;
   end

   // Pop reads head in the accept cycle; data lands with the result beat.
   // A push and a pop never share a cycle, so no forwarding is needed.
   bsw_ram #(
      .WIDTH (THREAD_W),
      .DEPTH (MAX_THREADS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (req_data.thread_id),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (ring_rdata)
   );

   always_comb begin
      rsp_data.status       = status_ff;
      rsp_data.woken_thread = (status_ff == ST_WOKEN) ? ring_rdata : '0;
      rsp_data.waiters      = waiters_ff;
   end

   assign rsp_strobe = rsp_valid_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("wait count above ring depth");

   a_free_empty : assert property (@(posedge clock) disable iff (reset)
      lock_free_ff |-> (count_ff == '0))
      else $error("lock free while threads wait");

   a_ptr_match : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with head and tail apart");

   a_one_beat : assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_we) |=> rsp_strobe)
      else $error("accepted request gave no result beat");

   a_woken_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (status_ff == ST_WOKEN)) |-> (waiters_ff < FULL_CNT))
      else $error("woken beat reports a full ring");

endmodule

FILE: test/tb_top.sv
// Self-checking bench for binary_semaphore_wait_queue: drives down/up request beats
// and checks every result beat against a queue-model scoreboard.
// Depends on bsw_pkg and the binary_semaphore_wait_queue RTL.
`timescale 1ns / 1ps

module tb_top;
   import bsw_pkg::*;

   localparam int IDLE_LIMIT = 200;
   localparam int NUM_PHASES = 7;

   // Tracks lock, wait ring and expected result beats.
   class semaphore_scoreboard;
      logic                lock_free;
      logic [THREAD_W-1:0] ring [MAX_THREADS];
      int                  head;
      int                  tail;
      int                  count;
      rsp_type             pending [$];
      int                  errors;

      function int next_slot(input int idx);
         return (idx == MAX_THREADS - 1) ? 0 : idx + 1;
      endfunction

      // Loading the lock value also empties the wait ring.
      function void load_lock(input logic value);
         lock_free = value;
         head      = 0;
         tail      = 0;
         count     = 0;
      endfunction

      function void note_request(input req_type req);
         rsp_type want;
         want = '0;
         if (req.func == FUNC_DOWN) begin
            if (lock_free) begin
               lock_free   = 1'b0;
               want.status = ST_ACQUIRED;
            end else if (count >= MAX_THREADS) begin
               want.status = ST_DROPPED;
            end else begin
               ring[tail]  = req.thread_id;
               tail        = next_slot(tail);
               count++;
               want.status = ST_QUEUED;
            end
         end else begin
            if (count > 0) begin
               want.woken_thread = ring[head];
               head              = next_slot(head);
               count--;
               want.status       = ST_WOKEN;
            end else begin
               lock_free   = 1'b1;
               want.status = ST_FREED;
            end
         end
         want.waiters = CNT_W'(count);
         pending.push_back(want);
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                      got.status));
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         got.status, want.status));
            if (got.woken_thread !== want.woken_thread)
               report_mismatch($sformatf("woken_thread got %0d expected %0d",
                                         got.woken_thread, want.woken_thread));
            if (got.waiters !== want.waiters)
               report_mismatch($sformatf("waiters got %0d expected %0d",
                                         got.waiters, want.waiters));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   semaphore_scoreboard sb = new;
   int idle_cycles = 0;

   binary_semaphore_wait_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample everything at the rising edge: results first, then config, then requests.
   always @(posedge clock) begin
      if (reset) begin
         sb.load_lock(1'b1);
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe)
            sb.check_result(rsp_data);
         if (csr_we)
            sb.load_lock(csr_wdata);
         if (start && !busy)
            sb.note_request(req_data);
         idle_cycles <= (rsp_strobe || (start && !busy)) ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("binary_semaphore_wait_queue regression: fail");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task send_beat(input logic func, input int tid, input int gap);
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_data.func      <= func;
      req_data.thread_id <= THREAD_W'(tid);
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   task wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0)
         @(negedge clock);
   endtask

   task write_initial_lock(input logic value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   function int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      endcase
   endfunction

   // Per phase: lock value, down percentage in first and second half, length, gap mode.
   int phase_lock [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1};
   int bias_fill  [NUM_PHASES] = '{50, 97, 90, 70, 99, 30, 60};
   int bias_drain [NUM_PHASES] = '{50, 20, 5, 30, 50, 80, 40};
   int phase_len  [NUM_PHASES] = '{120, 260, 200, 150, 200, 100, 100};
   int gap_mode   [NUM_PHASES] = '{1, 0, 2, 1, 0, 2, 1};

   initial begin
      int   bias;
      logic func;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset lock value, up on a free lock, FIFO order, id extremes.
      send_beat(FUNC_UP,   63, 0);
      send_beat(FUNC_DOWN, 0,  0);
      send_beat(FUNC_DOWN, 63, 1);
      send_beat(FUNC_DOWN, 42, 0);
      send_beat(FUNC_DOWN, 21, 3);
      send_beat(FUNC_UP,   0,  0);
      send_beat(FUNC_UP,   0,  2);
      send_beat(FUNC_DOWN, 0,  0);
      send_beat(FUNC_UP,   7,  0);
      send_beat(FUNC_UP,   0,  0);
      send_beat(FUNC_UP,   0,  1);
      send_beat(FUNC_UP,   0,  0);
      wait_drained();
      // Lock starts taken: first down queues at once.
      write_initial_lock(1'b0);
      send_beat(FUNC_DOWN, 63, 0);
      send_beat(FUNC_UP,   0,  0);
      send_beat(FUNC_UP,   0,  0);
      send_beat(FUNC_DOWN, 1,  0);
      send_beat(FUNC_DOWN, 5,  0);
      wait_drained();
      // Rewrite with a waiter pending: ring must be emptied.
      write_initial_lock(1'b1);
      send_beat(FUNC_DOWN, 10, 0);
      send_beat(FUNC_UP,   0,  0);
      send_beat(FUNC_UP,   0,  0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_initial_lock(phase_lock[p][0]);
         for (int i = 0; i < phase_len[p]; i++) begin
            bias = (i < phase_len[p] / 2) ? bias_fill[p] : bias_drain[p];
            func = ($urandom_range(0, 99) < bias) ? FUNC_DOWN : FUNC_UP;
            send_beat(func, $urandom_range(0, 63), draw_gap(gap_mode[p]));
         end
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (sb.pending.size() != 0)
         sb.report_mismatch($sformatf("%0d expected beats never arrived",
                                      sb.pending.size()));
      if (sb.errors == 0)
         $display("binary_semaphore_wait_queue regression: pass");
      else
         $display("binary_semaphore_wait_queue regression: fail");
      $finish;
   end

endmodule
